FILE: hw/rtl/tdmd_pkg.sv
// ----------------------------------------------------------------------------
// tdmd_pkg
// Shared types and constants for the tilt deviation motor drive.
// ----------------------------------------------------------------------------
`default_nettype none

package tdmd_pkg;

    // Default structural parameters
    localparam int WINDOW_LEN_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 16;

    // Q.16 fixed point
    localparam int FRAC_BITS  = 16;
    localparam int READING_W  = 17;              // 0 .. 65536
    localparam int DUTY_W     = 17;
    localparam int DEV_W      = 18;              // signed
    localparam int MEAN_W     = 17;
    localparam int DIR_W      = 2;
    localparam int GAIN_W     = 8;
    localparam int BAND_W     = 17;
    localparam int WARMUP_W   = 4;
    localparam int PROD_W     = GAIN_W + READING_W;
    localparam logic [DUTY_W-1:0] FULL_SCALE = 17'd65536;

    // Result transaction layout
    localparam int OUT_FIELDS_W = DIR_W + DUTY_W + DEV_W + MEAN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARMUP    = 2'd2;

    localparam logic [BAND_W-1:0]   RST_DEAD_BAND = 17'd8520;
    localparam logic [GAIN_W-1:0]   RST_GAIN      = 8'd40;
    localparam logic [WARMUP_W-1:0] RST_WARMUP    = 4'd3;

    // Divider: quotient bits, bits retired per step
    localparam int QUOT_W     = 18;
    localparam int RADIX_BITS = 2;
    localparam int DIV_STEPS  = QUOT_W / RADIX_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [DIR_W-1:0] {
        DIR_CW     = 2'd0,
        DIR_CCW    = 2'd1,
        DIR_STEADY = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_NORM,
        ST_UPD,
        ST_MEAN,
        ST_DEV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tdmd_window_mem.sv
// ----------------------------------------------------------------------------
// tdmd_window_mem
// Window storage: synchronous RAM with separate read and write ports, registered
// read, per-entry valid bits so that entries not written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmd_window_mem #(
    parameter int DEPTH  = tdmd_pkg::WINDOW_LEN_DEF,
    parameter int ADDR_W = $clog2(tdmd_pkg::WINDOW_LEN_DEF)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic [tdmd_pkg::READING_W-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [tdmd_pkg::READING_W-1:0] wr_data
);

    logic [tdmd_pkg::READING_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]               valid_reg;
    logic [tdmd_pkg::READING_W-1:0] q_reg;
    logic                           q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/tdmd_divider.sv
// ----------------------------------------------------------------------------
// tdmd_divider
// Restoring divider, two quotient bits per cycle. Quotient must be
// known to fit QUOT_W bits (dividend < divisor << QUOT_W).
// ----------------------------------------------------------------------------
`default_nettype none

module tdmd_divider #(
    parameter int DIV_W = tdmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [DIV_W+tdmd_pkg::QUOT_W-1:0]    dividend,
    input  logic [DIV_W-1:0]                     divisor,
    output tdmd_pkg::div_result_t                result
);

    localparam int QW = tdmd_pkg::QUOT_W;
    localparam logic [tdmd_pkg::DIV_CNT_W-1:0] LAST_STEP =
        tdmd_pkg::DIV_CNT_W'(tdmd_pkg::DIV_STEPS - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tdmd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [QW-1:0]                  qr_reg, qr_next;
    logic [DIV_W-1:0]               dsr_reg, dsr_next;

    logic [DIV_W:0]                 trial;
    logic [DIV_W-1:0]               rem_step;
    logic [QW-1:0]                  qr_step;

    // One step: RADIX_BITS shift/compare/subtract iterations
    always_comb
    begin
        trial    = '0;
        rem_step = rem_reg;
        qr_step  = qr_reg;
        for (int i = 0; i < tdmd_pkg::RADIX_BITS; i++)
        begin
            trial   = {rem_step, qr_step[QW-1]};
            qr_step = {qr_step[QW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial      = trial - {1'b0, dsr_reg};
                qr_step[0] = 1'b1;
            end
            rem_step = trial[DIV_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qr_next   = qr_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[DIV_W+QW-1:QW];
            qr_next   = dividend[QW-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            qr_next  = qr_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        dsr_reg <= dsr_next;
    end

    assign result = {done_reg, qr_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/tilt_deviation_motor_drive_core.sv
// ----------------------------------------------------------------------------
// tilt_deviation_motor_drive_core
// Proportional motor drive over a moving average of normalized gyro samples.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream: one signed gyro sample per transaction (s_tdata, low bits).
//  - m_* stream: one drive command per transaction once warmed up:
//    direction (0 cw, 1 ccw, 2 steady), duty, deviation, window_mean (Q.16).
//  - cfg_*: register writes (0 dead_band, 1 gain, 2 warmup_samples); always
//    ready, other indexes are dropped. Write only while the core is idle.
//  - One sample in flight at a time: the next sample is taken only after
//    the result of the last one loads into the output register. Most of the
//    time is spent in one pass through the radix-4 divider (9 steps) that
//    normalizes the sample into the min/max range; the window mean is a
//    reciprocal multiply, registered in its own state. With a zero range
//    the divider is skipped. Warm-up samples are taken straight from idle
//    and give no result.
//  - Window of WINDOW_LEN readings lives in a RAM with valid bits, so reset
//    is immediate (no clearing pass); reset also restores registers to
//    their defaults, resets min/max and clears the warm-up count.
//  - Results sit in an output register; if m_tready is low a new sample is
//    still accepted and processed, and the core waits at the end of that
//    sample until the previous result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_deviation_motor_drive_core #(
    parameter int WINDOW_LEN  = tdmd_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = tdmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
    // drive commands
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] direction, [18:2] duty, [36:19] deviation, [53:37] window_mean
    output logic [tdmd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tdmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int DIV_W   = SB;
    localparam int DVD_W   = DIV_W + tdmd_pkg::QUOT_W;
    localparam int TOTAL_W = tdmd_pkg::READING_W + SLOT_W;
    localparam int FB      = tdmd_pkg::FRAC_BITS;
    localparam int RW      = tdmd_pkg::READING_W;
    localparam int DW      = tdmd_pkg::DEV_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

    // Mean by reciprocal: ceil(2^RECIP_SH / WINDOW_LEN), exact for any total
    localparam int     RECIP_SH = TOTAL_W + SLOT_W;
    localparam int     RECIP_W  = TOTAL_W + 1;
    localparam int     MPROD_W  = TOTAL_W + RECIP_W;
    localparam longint RECIP_L  = ((longint'(1) << RECIP_SH) + longint'(WINDOW_LEN) - 1)
                                / longint'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tdmd_pkg::state_t                  state_reg, state_next;
    logic [tdmd_pkg::BAND_W-1:0]       dead_band_reg, dead_band_next;
    logic [tdmd_pkg::GAIN_W-1:0]       gain_reg, gain_next;
    logic [tdmd_pkg::WARMUP_W-1:0]     warmup_samples_reg, warmup_samples_next;
    logic [tdmd_pkg::WARMUP_W-1:0]     warmup_count_reg, warmup_count_next;
    logic signed [SB-1:0]              peak_high_reg, peak_high_next;
    logic signed [SB-1:0]              peak_low_reg, peak_low_next;
    logic [SLOT_W-1:0]                 slot_reg, slot_next;
    logic [TOTAL_W-1:0]                total_reg, total_next;
    logic                              out_valid_reg, out_valid_next;

    // payload, no reset
    logic signed [SB-1:0]              sample_reg, sample_next;
    logic [RW-1:0]                     reading_reg, reading_next;
    logic [tdmd_pkg::MEAN_W-1:0]       mean_reg, mean_next;
    logic signed [DW-1:0]              dev_reg, dev_next;
    logic [tdmd_pkg::DIR_W-1:0]        out_dir_reg, out_dir_next;
    logic [tdmd_pkg::DUTY_W-1:0]       out_duty_reg, out_duty_next;
    logic [DW-1:0]                     out_dev_reg, out_dev_next;
    logic [tdmd_pkg::MEAN_W-1:0]       out_mean_reg, out_mean_next;

    // ------------------------------------------------------------------
    // Datapath wires
    // ------------------------------------------------------------------
    logic signed [SB-1:0]              s_sample;
    logic signed [SB:0]                span_s, off_s;
    logic                              mem_rd_en, mem_wr_en;
    logic [RW-1:0]                     mem_rd_data;
    logic                              div_start;
    logic [DVD_W-1:0]                  div_dividend;
    logic [DIV_W-1:0]                  div_divisor;
    tdmd_pkg::div_result_t             div_res;
    logic [MPROD_W-1:0]                mean_prod;
    logic [RW-1:0]                     dev_mag;
    logic [tdmd_pkg::PROD_W-1:0]       duty_prod;
    logic [tdmd_pkg::DUTY_W-1:0]       duty_sat;
    logic signed [DW-1:0]              band_pos, band_neg;
    tdmd_pkg::dir_t                    dir_sel;
    logic                              out_load;

    assign s_sample  = s_tdata[SB-1:0];
    assign span_s    = {peak_high_reg[SB-1], peak_high_reg}
                     - {peak_low_reg[SB-1], peak_low_reg};
    assign off_s     = {sample_reg[SB-1], sample_reg}
                     - {peak_low_reg[SB-1], peak_low_reg};

    // Window mean from the registered running sum
    assign mean_prod = MPROD_W'(total_reg) * MPROD_W'(RECIP);

    // Drive decision from the registered deviation
    assign band_pos  = $signed({1'b0, dead_band_reg});
    assign band_neg  = -band_pos;
    assign dev_mag   = dev_reg[DW-1] ? RW'(-dev_reg) : dev_reg[RW-1:0];
    assign duty_prod = tdmd_pkg::PROD_W'(gain_reg) * tdmd_pkg::PROD_W'(dev_mag);
    assign duty_sat  = (duty_prod > tdmd_pkg::PROD_W'(tdmd_pkg::FULL_SCALE))
                     ? tdmd_pkg::FULL_SCALE : duty_prod[tdmd_pkg::DUTY_W-1:0];

    always_comb
    begin
        priority if (dev_reg > band_pos)
        begin
            dir_sel = tdmd_pkg::DIR_CW;
        end
        else if (dev_reg < band_neg)
        begin
            dir_sel = tdmd_pkg::DIR_CCW;
        end
        else
        begin
            dir_sel = tdmd_pkg::DIR_STEADY;
        end
    end

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    tdmd_window_mem #(
        .DEPTH  (WINDOW_LEN),
        .ADDR_W (SLOT_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (slot_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (reading_reg)
    );

    tdmd_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        dead_band_next      = dead_band_reg;
        gain_next           = gain_reg;
        warmup_samples_next = warmup_samples_reg;
        warmup_count_next   = warmup_count_reg;
        peak_high_next      = peak_high_reg;
        peak_low_next       = peak_low_reg;
        slot_next           = slot_reg;
        total_next          = total_reg;
        sample_next         = sample_reg;
        reading_next        = reading_reg;
        mean_next           = mean_reg;
        dev_next            = dev_reg;
        out_dir_next        = out_dir_reg;
        out_duty_next       = out_duty_reg;
        out_dev_next        = out_dev_reg;
        out_mean_next       = out_mean_reg;
        mem_rd_en           = 1'b0;
        mem_wr_en           = 1'b0;
        div_start           = 1'b0;
        div_dividend        = '0;
        div_divisor         = '0;
        out_load            = 1'b0;

        // config writes (the user must issue them only while idle; the core does not enforce this)
        if (cfg_valid)
        begin
            if (cfg_index == tdmd_pkg::CFG_DEAD_BAND)
            begin
                dead_band_next = cfg_data[tdmd_pkg::BAND_W-1:0];
            end
            else if (cfg_index == tdmd_pkg::CFG_GAIN)
            begin
                gain_next = cfg_data[tdmd_pkg::GAIN_W-1:0];
            end
            else if (cfg_index == tdmd_pkg::CFG_WARMUP)
            begin
                warmup_samples_next = cfg_data[tdmd_pkg::WARMUP_W-1:0];
            end
        end

        unique case (state_reg)
            tdmd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = s_sample;
                    if (s_sample > peak_high_reg)
                    begin
                        peak_high_next = s_sample;
                    end
                    if (s_sample < peak_low_reg)
                    begin
                        peak_low_next = s_sample;
                    end
                    if (warmup_count_reg < warmup_samples_reg)
                    begin
                        warmup_count_next = warmup_count_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = tdmd_pkg::ST_PREP;
                    end
                end
            end

            tdmd_pkg::ST_PREP:
            begin
                // fetch the entry about to be replaced
                mem_rd_en = 1'b1;
                if (span_s > 0)
                begin
                    div_start    = 1'b1;
                    div_dividend = DVD_W'({off_s[SB-1:0], FB'(0)});
                    div_divisor  = DIV_W'(span_s[SB-1:0]);
                    state_next   = tdmd_pkg::ST_NORM;
                end
                else
                begin
                    reading_next = '0;
                    state_next   = tdmd_pkg::ST_UPD;
                end
            end

            tdmd_pkg::ST_NORM:
            begin
                if (div_res.done)
                begin
                    reading_next = div_res.quotient[RW-1:0];
                    state_next   = tdmd_pkg::ST_UPD;
                end
            end

            tdmd_pkg::ST_UPD:
            begin
                // read-modify-write of the window slot and running sum
                total_next   = total_reg - TOTAL_W'(mem_rd_data) + TOTAL_W'(reading_reg);
                mem_wr_en    = 1'b1;
                slot_next    = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                state_next   = tdmd_pkg::ST_MEAN;
            end

            tdmd_pkg::ST_MEAN:
            begin
                // floor(total / WINDOW_LEN)
                mean_next  = mean_prod[RECIP_SH +: tdmd_pkg::MEAN_W];
                state_next = tdmd_pkg::ST_DEV;
            end

            tdmd_pkg::ST_DEV:
            begin
                dev_next   = $signed({1'b0, reading_reg}) - $signed({1'b0, mean_reg});
                state_next = tdmd_pkg::ST_EMIT;
            end

            tdmd_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    out_dir_next  = dir_sel;
                    out_duty_next = (dir_sel == tdmd_pkg::DIR_STEADY) ? '0 : duty_sat;
                    out_dev_next  = dev_reg;
                    out_mean_next = mean_reg;
                    state_next    = tdmd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tdmd_pkg::ST_IDLE;
            end
        endcase

        // output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= tdmd_pkg::ST_IDLE;
            dead_band_reg      <= tdmd_pkg::RST_DEAD_BAND;
            gain_reg           <= tdmd_pkg::RST_GAIN;
            warmup_samples_reg <= tdmd_pkg::RST_WARMUP;
            warmup_count_reg   <= '0;
            peak_high_reg      <= {1'b1, {(SB-1){1'b0}}};
            peak_low_reg       <= {1'b0, {(SB-1){1'b1}}};
            slot_reg           <= '0;
            total_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            dead_band_reg      <= dead_band_next;
            gain_reg           <= gain_next;
            warmup_samples_reg <= warmup_samples_next;
            warmup_count_reg   <= warmup_count_next;
            peak_high_reg      <= peak_high_next;
            peak_low_reg       <= peak_low_next;
            slot_reg           <= slot_next;
            total_reg          <= total_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        reading_reg  <= reading_next;
        mean_reg     <= mean_next;
        dev_reg      <= dev_next;
        out_dir_reg  <= out_dir_next;
        out_duty_reg <= out_duty_next;
        out_dev_reg  <= out_dev_next;
        out_mean_reg <= out_mean_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == tdmd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = tdmd_pkg::OUT_TDATA_W'({out_mean_reg, out_dev_reg,
                                               out_duty_reg, out_dir_reg});

endmodule

`default_nettype wire

FILE: hw/rtl/tdmd_checker.sv
// ----------------------------------------------------------------------------
// tdmd_checker
// Port-level checks on the drive command stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [tdmd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == tdmd_pkg::DIR_CW)
                  || (m_tdata[1:0] == tdmd_pkg::DIR_CCW)
                  || (m_tdata[1:0] == tdmd_pkg::DIR_STEADY))
        else $error("unused direction code");

    a_steady_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == tdmd_pkg::DIR_STEADY) |-> (m_tdata[18:2] == '0))
        else $error("duty nonzero while steady");

    a_duty_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18:2] <= tdmd_pkg::FULL_SCALE))
        else $error("duty above full scale");

endmodule

bind tilt_deviation_motor_drive_core tdmd_checker u_tdmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
